// File: design/agmas_pkg.sv
// shared types and constants for the gated moving-average scaler
// no dependencies; imported by the controller, datapath and top level
package agmas_pkg;

    // field widths
    localparam int CH_W       = 2;
    localparam int SAMPLE_W   = 12;
    localparam int CNT_W      = 4;
    localparam int GAIN_W     = 32;
    localparam int SCALED_W   = 16;
    localparam int Q_FRAC     = 16;
    localparam int SUM_W      = SAMPLE_W + CNT_W;
    localparam int PROD_W     = SAMPLE_W + GAIN_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int DIV_STEPS  = SAMPLE_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_VOLT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CURR   = 2'd2;

    // register reset values
    localparam logic [SAMPLE_W-1:0] OFFSET_RESET    = 12'd0;
    localparam logic [GAIN_W-1:0]   VOLT_GAIN_RESET = 32'd103788;
    localparam logic [GAIN_W-1:0]   CURR_GAIN_RESET = 32'd15000;

    // channel that uses the current gain
    localparam logic [CH_W-1:0] CURR_CHANNEL = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_STORE,
        ST_SUM,
        ST_DIV,
        ST_WRBACK,
        ST_MUL,
        ST_FINISH
    } agmas_state_t;

    typedef struct packed {
        logic latch;
        logic store;
        logic sum_step;
        logic div_load;
        logic div_step;
        logic hold_write;
        logic mul;
        logic finish;
    } agmas_cmd_t;

    typedef struct packed {
        logic ch_valid;
        logic above_thr;
        logic sum_done;
        logic div_done;
        logic out_free;
    } agmas_status_t;

endpackage

// File: design/adc_gated_moving_average_scaler.sv
// top level of the gated moving-average scaler: controller plus datapath
// depends on agmas_pkg, agmas_ctrl and agmas_dpath
//
// channel  | direction | handshake             | payload
// ---------+-----------+-----------------------+-----------------------------------------
// in       | input     | in_valid / in_stall   | channel, sample
// out      | output    | out_valid / out_stall | out_channel, average, scaled_value,
//          |           |                       | fill_count
// cfg      | input     | cfg_we                | cfg_index, cfg_data
//
// a stored sample passes through store, the read-and-add pass over the ring memory,
// the twelve-step divider, the write-back of the average and the multiply before it
// is loaded into the output register
// a sample at or below the threshold skips to the multiply, an unknown channel to the
// final load; the next request can be taken once the result is loaded
// reset clears pointers, counts, held averages and config; the sample memory is not
// cleared and needs no clearing pass, since every slot is written before it is read
// a stalled result sits in the output register while the next request is taken in;
// only the final load waits for the output register to free up
module adc_gated_moving_average_scaler #(
    parameter int BUF_LEN      = 16,
    parameter int NUM_CHANNELS = 3
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration writes
    input  logic                                cfg_we,
    input  logic [agmas_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [agmas_pkg::CFG_DATA_W-1:0]    cfg_data,
    // sample requests
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [agmas_pkg::CH_W-1:0]          channel,
    input  logic [agmas_pkg::SAMPLE_W-1:0]      sample,
    // results
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [agmas_pkg::CH_W-1:0]          out_channel,
    output logic [agmas_pkg::SAMPLE_W-1:0]      average,
    output logic [agmas_pkg::SCALED_W-1:0]      scaled_value,
    output logic [agmas_pkg::CNT_W-1:0]         fill_count
);
    import agmas_pkg::*;

    // command and status bundles between the state machine and the datapath
    agmas_cmd_t    cmd;
    agmas_status_t status;

    // sequencer: accepts a request, walks a sample above the threshold through store, sum, divide, scale
    agmas_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // ring memory, per-channel pointers, accumulator, divider, multiplier, output register
    agmas_dpath #(
        .BUF_LEN      (BUF_LEN),
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .channel      (channel),
        .sample       (sample),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_channel  (out_channel),
        .average      (average),
        .scaled_value (scaled_value),
        .fill_count   (fill_count)
    );

    // a ring never reports more entries than it can keep
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (int'(fill_count) <= BUF_LEN - 1))
    else $error("fill count beyond ring capacity");

    // a request just taken holds off the next one
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
    else $error("second request taken while one is in progress");

    // an unknown channel gives an all-zero result
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (int'(out_channel) >= NUM_CHANNELS))
            |-> (average == '0 && scaled_value == '0 && fill_count == '0))
    else $error("unknown channel returned non-zero result");

    // the datapath is never asked to do two exclusive steps at once
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.latch, cmd.store, cmd.div_step, cmd.hold_write, cmd.mul, cmd.finish}))
    else $error("conflicting datapath commands");

endmodule

// File: design/agmas_ctrl.sv
// sequencing state machine for the gated moving-average scaler
// depends on agmas_pkg for the state, command and status types
module agmas_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  agmas_pkg::agmas_status_t status,
    output agmas_pkg::agmas_cmd_t    cmd
);
    import agmas_pkg::*;

    agmas_state_t state_reg;
    agmas_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (!status.ch_valid)
                begin
                    state_next = ST_FINISH;
                end
                else if (status.above_thr)
                begin
                    state_next = ST_STORE;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_STORE:
            begin
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                if (status.sum_done)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_WRBACK;
                end
            end
            ST_WRBACK:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.latch = in_valid;
            end
            ST_LOAD:
            begin
            end
            ST_STORE:
            begin
                cmd.store = 1'b1;
            end
            ST_SUM:
            begin
                cmd.sum_step = 1'b1;
                cmd.div_load = status.sum_done;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_WRBACK:
            begin
                cmd.hold_write = 1'b1;
            end
            ST_MUL:
            begin
                cmd.mul = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.finish = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: design/agmas_dpath.sv
// datapath: config registers, sample ring memory, summing, divider, gain multiplier
// and output register; depends on agmas_pkg
module agmas_dpath #(
    parameter int BUF_LEN      = 16,
    parameter int NUM_CHANNELS = 3
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [agmas_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [agmas_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [agmas_pkg::CH_W-1:0]          channel,
    input  logic [agmas_pkg::SAMPLE_W-1:0]      sample,
    input  agmas_pkg::agmas_cmd_t               cmd,
    output agmas_pkg::agmas_status_t            status,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [agmas_pkg::CH_W-1:0]          out_channel,
    output logic [agmas_pkg::SAMPLE_W-1:0]      average,
    output logic [agmas_pkg::SCALED_W-1:0]      scaled_value,
    output logic [agmas_pkg::CNT_W-1:0]         fill_count
);
    import agmas_pkg::*;

    localparam int PTR_W    = $clog2(BUF_LEN);
    localparam int DEPTH    = NUM_CHANNELS * BUF_LEN;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(BUF_LEN - 1);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(BUF_LEN - 1);
    localparam logic [ADDR_W-1:0] BUF_LEN_A = ADDR_W'(BUF_LEN);

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    // configuration
    logic [SAMPLE_W-1:0] thr_reg;
    logic [GAIN_W-1:0]   volt_gain_reg;
    logic [GAIN_W-1:0]   curr_gain_reg;

    // current request
    logic [CH_W-1:0]     ch_reg;
    logic [SAMPLE_W-1:0] sample_reg;

    // per-channel ring state
    logic [PTR_W-1:0]    op_reg   [NUM_CHANNELS];
    logic [PTR_W-1:0]    wp_reg   [NUM_CHANNELS];
    logic [CNT_W-1:0]    cnt_reg  [NUM_CHANNELS];
    logic [SAMPLE_W-1:0] held_reg [NUM_CHANNELS];

    // sample memory
    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;

    // summing
    logic [PTR_W-1:0]    rptr_reg;
    logic [CNT_W-1:0]    rd_left_reg;
    logic                pend_reg;
    logic [SUM_W-1:0]    acc_reg;
    logic [SUM_W-1:0]    acc_next;

    // divider
    logic [CNT_W-1:0]     rem_reg;
    logic [CNT_W-1:0]     rem_next;
    logic [SAMPLE_W-1:0]  quo_reg;
    logic [SAMPLE_W-1:0]  quo_next;
    logic [DIV_CNT_W-1:0] div_left_reg;
    logic [CNT_W:0]       trial;
    logic                 trial_ge;

    // multiplier and output
    logic [PROD_W-1:0]    prod_reg;
    logic [SCALED_W-1:0]  scaled_sat;
    logic                 out_valid_reg;
    logic [CH_W-1:0]      out_channel_reg;
    logic [SAMPLE_W-1:0]  average_reg;
    logic [SCALED_W-1:0]  scaled_reg;
    logic [CNT_W-1:0]     fill_reg;

    logic [CH_IDX_W-1:0] ch_idx;
    logic                ch_valid;
    logic [PTR_W-1:0]    cur_op;
    logic [PTR_W-1:0]    cur_wp;
    logic [CNT_W-1:0]    cur_cnt;
    logic [SAMPLE_W-1:0] cur_held;
    logic [PTR_W-1:0]    wp_new;
    logic [PTR_W-1:0]    op_new;
    logic [CNT_W-1:0]    cnt_new;
    logic [ADDR_W-1:0]   base;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ADDR_W-1:0]   rd_addr;
    logic                rd_en;
    logic [GAIN_W-1:0]   gain;
    logic                out_free;

    assign ch_idx   = CH_IDX_W'(ch_reg);
    assign ch_valid = (int'(ch_reg) < NUM_CHANNELS);
    assign cur_op   = op_reg[ch_idx];
    assign cur_wp   = wp_reg[ch_idx];
    assign cur_cnt  = cnt_reg[ch_idx];
    assign cur_held = held_reg[ch_idx];

    // a full ring drops its oldest entry
    assign wp_new  = ring_next(cur_wp);
    assign op_new  = (wp_new == cur_op) ? ring_next(cur_op) : cur_op;
    assign cnt_new = (cur_cnt == CNT_FULL) ? cur_cnt : cur_cnt + 1'b1;

    assign base    = ADDR_W'(ch_idx) * BUF_LEN_A;
    assign wr_addr = base + ADDR_W'(cur_wp);
    assign rd_addr = base + ADDR_W'(rptr_reg);
    assign rd_en   = cmd.sum_step && (rd_left_reg != '0);

    assign gain     = (ch_reg == CURR_CHANNEL) ? curr_gain_reg : volt_gain_reg;
    assign out_free = !out_valid_reg || !out_stall;

    assign status.ch_valid  = ch_valid;
    assign status.above_thr = (sample_reg > thr_reg);
    assign status.sum_done  = (rd_left_reg == '0) && !pend_reg;
    assign status.div_done  = (div_left_reg == '0);
    assign status.out_free  = out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= OFFSET_RESET;
            volt_gain_reg <= VOLT_GAIN_RESET;
            curr_gain_reg <= CURR_GAIN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IDX_OFFSET: thr_reg       <= cfg_data[SAMPLE_W-1:0];
                CFG_IDX_VOLT:   volt_gain_reg <= cfg_data[GAIN_W-1:0];
                CFG_IDX_CURR:   curr_gain_reg <= cfg_data[GAIN_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            ch_reg     <= channel;
            sample_reg <= sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                op_reg[i]   <= '0;
                wp_reg[i]   <= '0;
                cnt_reg[i]  <= '0;
                held_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.store)
            begin
                op_reg[ch_idx]  <= op_new;
                wp_reg[ch_idx]  <= wp_new;
                cnt_reg[ch_idx] <= cnt_new;
            end
            if (cmd.hold_write)
            begin
                held_reg[ch_idx] <= quo_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            mem[wr_addr] <= sample_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // one read a cycle from the oldest entry on; read data is registered before it is added to the sum
    assign acc_next = pend_reg ? acc_reg + SUM_W'(rd_data_reg) : acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_left_reg <= '0;
            pend_reg    <= 1'b0;
        end
        else if (cmd.store)
        begin
            rd_left_reg <= cnt_new;
            pend_reg    <= 1'b0;
        end
        else if (cmd.sum_step)
        begin
            if (rd_en)
            begin
                rd_left_reg <= rd_left_reg - 1'b1;
            end
            pend_reg <= rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            rptr_reg <= op_new;
            acc_reg  <= '0;
        end
        else if (cmd.sum_step)
        begin
            if (rd_en)
            begin
                rptr_reg <= ring_next(rptr_reg);
            end
            acc_reg <= acc_next;
        end
    end

    // restoring divider, one quotient bit a step; the sum is below count * 4096
    // so its top bits already sit below the divisor
    assign trial    = {rem_reg, quo_reg[SAMPLE_W-1]};
    assign trial_ge = (trial >= {1'b0, cur_cnt});
    assign rem_next = trial_ge ? CNT_W'(trial - {1'b0, cur_cnt}) : trial[CNT_W-1:0];
    assign quo_next = {quo_reg[SAMPLE_W-2:0], trial_ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_left_reg <= '0;
        end
        else if (cmd.div_load)
        begin
            div_left_reg <= DIV_CNT_W'(DIV_STEPS);
        end
        else if (cmd.div_step && (div_left_reg != '0))
        begin
            div_left_reg <= div_left_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            rem_reg <= acc_reg[SUM_W-1 -: CNT_W];
            quo_reg <= acc_reg[SAMPLE_W-1:0];
        end
        else if (cmd.div_step && (div_left_reg != '0))
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(cur_held) * PROD_W'(gain);
        end
    end

    assign scaled_sat = (|prod_reg[PROD_W-1:Q_FRAC+SCALED_W]) ? '1
                                                               : prod_reg[Q_FRAC+SCALED_W-1:Q_FRAC];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_channel_reg <= ch_reg;
            average_reg     <= ch_valid ? cur_held : '0;
            scaled_reg      <= ch_valid ? scaled_sat : '0;
            fill_reg        <= ch_valid ? cur_cnt : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_channel  = out_channel_reg;
    assign average      = average_reg;
    assign scaled_value = scaled_reg;
    assign fill_count   = fill_reg;

endmodule
